FILE: rtl/fwrf_pkg.sv
// Shared constants, command/status types and the digit encoder for the radix formatter.
package fwrf_pkg;

	// Default field capacity in characters
	localparam int DEF_MAX_WIDTH = 16;

	// Fixed field widths of a request
	localparam int NUM_W   = 16;
	localparam int BASE_W  = 6;
	localparam int FW_W    = 5;
	localparam int CHAR_W  = 8;
	localparam int DSTEP_W = $clog2(NUM_W);

	// Radix limits
	localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
	localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;

	// Character constants
	localparam logic [CHAR_W-1:0] DIGIT_BASE     = 8'h30;
	localparam logic [CHAR_W-1:0] ALPHA_SKIP     = 8'd7;
	localparam logic [BASE_W-1:0] DECIMAL_DIGITS = 6'd10;
	localparam logic [CHAR_W-1:0] MINUS_CHAR     = 8'h2D;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;       // capture an accepted request
		logic div_start;  // start one division of the magnitude by the radix
		logic digit_wr;   // store the digit, take the quotient, step the position
		logic emit_ld;    // load the next character into the output register
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic div_busy;
		logic div_done;
		logic last_digit; // quotient is zero or no position is left
		logic emit_last;  // current character is the rightmost of the field
		logic out_free;   // output register can take a character this cycle
	} sts_t;

	// Digit value 0..35 to '0'-'9', 'A'-'Z'
	function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d);
		logic [CHAR_W-1:0] c;
		c = DIGIT_BASE + CHAR_W'(d);
		if (d >= DECIMAL_DIGITS) begin
			c = c + ALPHA_SKIP;
		end
		return c;
	endfunction

endpackage

FILE: rtl/fwrf_if.sv
// Request and result channel interfaces of the radix formatter.
interface fwrf_req_if;
	logic                valid;
	logic                ready;
	logic signed [15:0]  number;
	logic        [4:0]   field_width;
	logic        [7:0]   fill_char;
	logic        [5:0]   base;

	modport source (output valid, number, field_width, fill_char, base, input ready);
	modport sink   (input valid, number, field_width, fill_char, base, output ready);
endinterface

interface fwrf_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last;

	modport source (output valid, out_char, last, input ready);
	modport sink   (input valid, out_char, last, output ready);
endinterface

FILE: rtl/fwrf_div.sv
// Restoring divider: 16-bit magnitude by a 6-bit radix, one quotient bit per cycle.
module fwrf_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] dividend,
	input  logic [5:0]  divisor,
	output logic [15:0] quotient,
	output logic [5:0]  remainder,
	output logic        busy,
	output logic        done
);
	import fwrf_pkg::*;

	logic [NUM_W-1:0]   work_q;
	logic [BASE_W-1:0]  rem_q;
	logic [DSTEP_W-1:0] cnt_q;
	logic               busy_q;
	logic               done_q;

	logic [BASE_W:0]    trial;
	logic               ge;

	// Shift in the next dividend bit and try a subtract
	always_comb begin
		trial = {rem_q, work_q[NUM_W-1]};
		ge    = trial >= {1'b0, divisor};
	end

	// Control: step counter and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DSTEP_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remaining dividend bits and quotient share the shift register
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
		end else if (busy_q) begin
			work_q <= {work_q[NUM_W-2:0], ge};
			rem_q  <= ge ? BASE_W'(trial - {1'b0, divisor}) : trial[BASE_W-1:0];
		end
	end

	assign quotient  = work_q;
	assign remainder = rem_q;
	assign busy      = busy_q;
	assign done      = done_q;

`ifndef SYNTHESIS
	// A new division never starts on top of a running one
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");
`endif

endmodule

FILE: rtl/fwrf_datapath.sv
// Datapath: request registers, divider, character buffer and output register.
module fwrf_datapath #(
	parameter int MAX_WIDTH = fwrf_pkg::DEF_MAX_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fwrf_pkg::cmd_t     cmd,
	output fwrf_pkg::sts_t     sts,
	input  logic signed [15:0] number,
	input  logic [4:0]         field_width,
	input  logic [7:0]         fill_char,
	input  logic [5:0]         base,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [7:0]         out_char,
	output logic               out_last
);
	import fwrf_pkg::*;

	localparam int CNT_W = $clog2(MAX_WIDTH + 1);
	localparam int IDX_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	// Request state
	logic [NUM_W-1:0]  mag_q;
	logic [BASE_W-1:0] radix_q;
	logic              neg_q;
	logic [CHAR_W-1:0] fill_q;
	logic [CNT_W-1:0]  w_q;
	logic [CNT_W-1:0]  pos_q;
	logic [CNT_W-1:0]  k_q;

	// Digit buffer, written before it is read
	logic [CHAR_W-1:0] buf_q [MAX_WIDTH];

	// Output register
	logic              out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic              out_last_q;

	logic [NUM_W-1:0]  quo;
	logic [BASE_W-1:0] rem;
	logic              div_busy;
	logic              div_done;

	logic [BASE_W-1:0] radix_sat;
	logic [5:0]        fw_ext;
	logic [5:0]        w_tmp;
	logic [NUM_W-1:0]  mag_in;
	logic [CNT_W-1:0]  pos_m1;
	logic [CHAR_W-1:0] emit_char;

	fwrf_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (mag_q),
		.divisor   (radix_q),
		.quotient  (quo),
		.remainder (rem),
		.busy      (div_busy),
		.done      (div_done)
	);

	// Request decode: saturate radix and width, take magnitude
	always_comb begin
		if (base < BASE_MIN) begin
			radix_sat = BASE_MIN;
		end else if (base > BASE_MAX) begin
			radix_sat = BASE_MAX;
		end else begin
			radix_sat = base;
		end
		fw_ext = {1'b0, field_width};
		if (fw_ext == 6'd0) begin
			w_tmp = 6'd1;
		end else if (fw_ext > 6'(MAX_WIDTH)) begin
			w_tmp = 6'(MAX_WIDTH);
		end else begin
			w_tmp = fw_ext;
		end
		mag_in = number[NUM_W-1] ? NUM_W'(-number) : NUM_W'(number);
		pos_m1 = pos_q - 1'b1;
	end

	// Character at field position k: digit, sign or fill
	always_comb begin
		if (k_q >= pos_q) begin
			emit_char = buf_q[k_q[IDX_W-1:0]];
		end else if (neg_q && (CNT_W'(k_q + 1'b1) == pos_q)) begin
			emit_char = MINUS_CHAR;
		end else begin
			emit_char = fill_q;
		end
	end

	// Request registers and digit position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q <= '0;
			pos_q <= '0;
			k_q   <= '0;
		end else begin
			if (cmd.load) begin
				mag_q <= mag_in;
				pos_q <= CNT_W'(w_tmp);
				k_q   <= '0;
			end else begin
				if (cmd.digit_wr) begin
					mag_q <= quo;
					pos_q <= pos_m1;
				end
				if (cmd.emit_ld) begin
					k_q <= k_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			radix_q <= radix_sat;
			neg_q   <= number[NUM_W-1];
			fill_q  <= fill_char;
			w_q     <= CNT_W'(w_tmp);
		end
		if (cmd.digit_wr) begin
			buf_q[pos_m1[IDX_W-1:0]] <= digit_char(rem);
		end
	end

	// Output register: holds one character until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_ld) begin
			out_char_q <= emit_char;
			out_last_q <= (k_q == w_q - 1'b1);
		end
	end

	// Status
	always_comb begin
		sts.div_busy   = div_busy;
		sts.div_done   = div_done;
		sts.last_digit = (quo == '0) || (pos_q == CNT_W'(1));
		sts.emit_last  = (k_q == w_q - 1'b1);
		sts.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

`ifndef SYNTHESIS
	// A digit is only written while a position is free
	a_digit_in_field: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.digit_wr |-> (pos_q != '0))
		else $error("digit written with no free position");

	// A pending character is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_ld |-> (!out_valid_q || out_ready))
		else $error("output register overwritten");
`endif

endmodule

FILE: rtl/fwrf_ctrl.sv
// Controller: sequences capture, digit divisions and character emission.
module fwrf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  fwrf_pkg::sts_t sts,
	output fwrf_pkg::cmd_t cmd
);
	import fwrf_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_START = 4'b0010,
		S_DIV   = 4'b0100,
		S_EMIT  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nx;

	// Next state and commands
	always_comb begin
		state_nx  = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_nx = S_START;
				end
			end
			S_START: begin
				cmd.div_start = 1'b1;
				state_nx      = S_DIV;
			end
			S_DIV: begin
				if (sts.div_done) begin
					cmd.digit_wr = 1'b1;
					state_nx     = sts.last_digit ? S_EMIT : S_START;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_ld = 1'b1;
					if (sts.emit_last) begin
						state_nx = S_IDLE;
					end
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

`ifndef SYNTHESIS
	// A request is only taken with the divider at rest
	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> !sts.div_busy)
		else $error("request taken while divider busy");

	// A digit is stored only when a division has finished
	a_digit_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.digit_wr |-> sts.div_done)
		else $error("digit stored without finished division");
`endif

endmodule

FILE: rtl/fixed_width_radix_formatter_core.sv
// Sequence: a capture step, then for each digit a divider start, the serial quotient
// bits and a digit store, then one character per cycle while the result side is ready.
// A request yields at most W digits, W the field width, all from the one bit-serial
// divider shared by all digits.
// A new request is taken while the last character still waits in the output register.
// Reset: arst_n clears controller, divider control, magnitude, positions and output valid; the buffer is not reset.
module fixed_width_radix_formatter_core #(
	parameter int MAX_WIDTH = fwrf_pkg::DEF_MAX_WIDTH
) (
	input  logic       clk,
	input  logic       arst_n,
	fwrf_req_if.sink   request,
	fwrf_rsp_if.source result
);
	import fwrf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	fwrf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (request.valid),
		.req_ready (request.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	fwrf_datapath #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.number      (request.number),
		.field_width (request.field_width),
		.fill_char   (request.fill_char),
		.base        (request.base),
		.out_ready   (result.ready),
		.out_valid   (result.valid),
		.out_char    (result.out_char),
		.out_last    (result.last)
	);

endmodule

FILE: verif/fixed_width_radix_formatter_core_tb.sv
// Self-checking testbench of the fixed-width radix formatter core.
module fixed_width_radix_formatter_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fwrf_pkg::*;

	localparam int FIELD_MAX   = DEF_MAX_WIDTH;
	localparam int RANDOM_REQS = 360;
	localparam int HOLD_AT     = 40;    // requests taken before the long result stall
	localparam int HOLD_LEN    = 1500;  // cycles of that stall
	localparam int CALM_FROM   = 150;
	localparam int CALM_TO     = 230;
	localparam int TAIL_CYCLES = 40;

	typedef struct {
		logic signed [NUM_W-1:0]  number;
		logic        [FW_W-1:0]   width;
		logic        [CHAR_W-1:0] fill;
		logic        [BASE_W-1:0] base;
	} fmt_req_t;

	typedef struct {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} field_char_t;

	logic clk;
	logic arst_n;

	fwrf_req_if req_ch ();
	fwrf_rsp_if rsp_ch ();

	fixed_width_radix_formatter_core #(
		.MAX_WIDTH(FIELD_MAX)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.request(req_ch),
		.result (rsp_ch)
	);

	fmt_req_t    pending_reqs[$];
	field_char_t field_chars[$];
	int          reqs_taken = 0;
	int          errors = 0;
	logic        req_taken = 1'b0;
	logic        calm;
	int          hold_left = 0;
	logic        hold_done = 1'b0;

	// Both sides run without gaps for a stretch of requests
	assign calm = (reqs_taken >= CALM_FROM) && (reqs_taken < CALM_TO);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Expected characters of one request, leftmost first
	function automatic void format_field(input fmt_req_t r);
		logic [CHAR_W-1:0] chars [FIELD_MAX];
		int                w;
		int                radix;
		int                mag;
		int                pos;
		int                d;
		logic              negative;
		field_char_t       fc;
		w = r.width;
		if (w == 0) begin
			w = 1;
		end
		if (w > FIELD_MAX) begin
			w = FIELD_MAX;
		end
		radix = r.base;
		if (radix < BASE_MIN) begin
			radix = BASE_MIN;
		end
		if (radix > BASE_MAX) begin
			radix = BASE_MAX;
		end
		negative = r.number[NUM_W-1];
		mag = negative ? -int'(r.number) : int'(r.number);
		for (int k = 0; k < w; k++) begin
			chars[k] = r.fill;
		end
		// digits right-aligned; top digits that do not fit are dropped
		pos = w;
		do begin
			d = mag % radix;
			chars[pos-1] = DIGIT_BASE + CHAR_W'(d);
			if (d >= DECIMAL_DIGITS) begin
				chars[pos-1] = chars[pos-1] + ALPHA_SKIP;
			end
			mag = mag / radix;
			pos--;
		end while (mag != 0 && pos != 0);
		if (negative && pos != 0) begin
			chars[pos-1] = MINUS_CHAR;
		end
		for (int k = 0; k < w; k++) begin
			fc.ch = chars[k];
			fc.last = (k == w - 1);
			field_chars.push_back(fc);
		end
	endfunction

	function automatic fmt_req_t mk_req(input int number, input int width,
			input int fill, input int base);
		fmt_req_t r;
		r.number = NUM_W'(number);
		r.width = FW_W'(width);
		r.fill = CHAR_W'(fill);
		r.base = BASE_W'(base);
		return r;
	endfunction

	function automatic fmt_req_t random_req();
		fmt_req_t r;
		int       sel;
		sel = $urandom_range(0, 99);
		if (sel < 40) begin
			r.number = NUM_W'($urandom);
		end else if (sel < 65) begin
			r.number = NUM_W'(int'($urandom_range(0, 80)) - 40);
		end else if (sel < 80) begin
			r.number = sel[0] ? NUM_W'(-32768 + int'($urandom_range(0, 3)))
				: NUM_W'(32767 - int'($urandom_range(0, 3)));
		end else begin
			r.number = NUM_W'(int'($urandom_range(0, 4000)) - 2000);
		end
		r.width = ($urandom_range(0, 99) < 85) ? FW_W'($urandom_range(0, FIELD_MAX))
			: FW_W'($urandom_range(FIELD_MAX + 1, 31));
		r.base = ($urandom_range(0, 99) < 80) ? BASE_W'($urandom_range(2, 36))
			: BASE_W'($urandom_range(0, 63));
		sel = $urandom_range(0, 99);
		if (sel < 70) begin
			r.fill = CHAR_W'($urandom);
		end else begin
			r.fill = sel[0] ? 8'h20 : 8'h30;
		end
		return r;
	endfunction

	// Wait until every queued request is taken and every character has come;
	// checked at the rising edge, where the driver's outputs are settled
	task automatic drain_wait();
		while (pending_reqs.size() != 0 || req_ch.valid || field_chars.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Request driver: new request at the falling edge once the last one was taken
	always @(negedge clk) begin : req_driver
		fmt_req_t nxt;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_taken) begin
			if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 34)) begin
				nxt = pending_reqs.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.number <= nxt.number;
				req_ch.field_width <= nxt.width;
				req_ch.fill_char <= nxt.fill;
				req_ch.base <= nxt.base;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Result side: random stalls, one long hold-off, a calm stretch
	always @(negedge clk) begin : rsp_driver
		logic ready_next;
		if (!arst_n) begin
			ready_next = 1'b0;
		end else if (hold_left != 0) begin
			ready_next = 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && reqs_taken >= HOLD_AT) begin
			ready_next = 1'b0;
			hold_left <= HOLD_LEN;
			hold_done <= 1'b1;
		end else if (calm) begin
			ready_next = 1'b1;
		end else begin
			ready_next = ($urandom_range(0, 99) >= 34);
		end
		rsp_ch.ready <= ready_next;
	end

	// Monitor: check taken characters, then predict for a taken request
	always @(posedge clk) begin : monitor
		field_char_t exp_c;
		fmt_req_t    r;
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else begin
			req_taken <= req_ch.valid && req_ch.ready;
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (field_chars.size() == 0) begin
					$error("unexpected character %h last %b", rsp_ch.out_char, rsp_ch.last);
					errors++;
				end else begin
					exp_c = field_chars.pop_front();
					if (rsp_ch.out_char !== exp_c.ch) begin
						$error("out_char mismatch: expected %h actual %h",
							exp_c.ch, rsp_ch.out_char);
						errors++;
					end
					if (rsp_ch.last !== exp_c.last) begin
						$error("last mismatch: expected %b actual %b",
							exp_c.last, rsp_ch.last);
						errors++;
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				r.number = req_ch.number;
				r.width = req_ch.field_width;
				r.fill = req_ch.fill_char;
				r.base = req_ch.base;
				format_field(r);
				reqs_taken++;
			end
		end
	end

	// Stimulus and end of run
	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.number = '0;
		req_ch.field_width = '0;
		req_ch.fill_char = '0;
		req_ch.base = '0;
		rsp_ch.ready = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// zero, zero width, extremes, saturation, dropped digits, sign placement
		pending_reqs.push_back(mk_req(0, 0, 8'h20, 10));
		pending_reqs.push_back(mk_req(0, 5, 8'h2A, 2));
		pending_reqs.push_back(mk_req(32767, 16, 8'h20, 2));
		pending_reqs.push_back(mk_req(-32768, 16, 8'h20, 2));
		pending_reqs.push_back(mk_req(-32768, 7, 8'h20, 10));
		pending_reqs.push_back(mk_req(-32768, 3, 8'h23, 10));
		pending_reqs.push_back(mk_req(-123, 3, 8'h20, 10));
		pending_reqs.push_back(mk_req(-123, 4, 8'h30, 10));
		pending_reqs.push_back(mk_req(12345, 31, 8'h2E, 0));
		pending_reqs.push_back(mk_req(255, 17, 8'h5F, 1));
		pending_reqs.push_back(mk_req(35, 2, 8'h20, 36));
		pending_reqs.push_back(mk_req(-1295, 5, 8'hFF, 63));
		pending_reqs.push_back(mk_req(-1, 1, 8'h00, 37));
		pending_reqs.push_back(mk_req(2748, 8, 8'h20, 16));
		pending_reqs.push_back(mk_req(-2748, 8, 8'h20, 16));
		pending_reqs.push_back(mk_req(1000, 16, 8'h80, 35));
		pending_reqs.push_back(mk_req(-9, 2, 8'h20, 9));
		pending_reqs.push_back(mk_req(7, 31, 8'h7F, 62));
		pending_reqs.push_back(mk_req(-32767, 16, 8'h01, 3));
		pending_reqs.push_back(mk_req(100, 1, 8'hAA, 10));

		// sender pauses until the block is empty
		drain_wait();

		for (int i = 0; i < RANDOM_REQS; i++) begin
			pending_reqs.push_back(random_req());
		end
		drain_wait();
		repeat (TAIL_CYCLES) @(negedge clk);

		if (errors == 0 && field_chars.size() == 0 && pending_reqs.size() == 0) begin
			$display("fixed_width_radix_formatter_core_tb OK");
		end else begin
			$display("fixed_width_radix_formatter_core_tb NOT OK");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#12_000_000;
		$display("fixed_width_radix_formatter_core_tb NOT OK");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/fwrf_pkg.sv
rtl/fwrf_if.sv
rtl/fwrf_div.sv
rtl/fwrf_datapath.sv
rtl/fwrf_ctrl.sv
rtl/fixed_width_radix_formatter_core.sv
verif/fixed_width_radix_formatter_core_tb.sv
